// ===== rtl/dlr_pkg.sv =====
// shared types and constants of the dda line rasterizer
`default_nettype none
package dlr_pkg;

  localparam int COORD_BITS   = 11;
  localparam int FRAC_BITS    = 16;
  localparam int ACC_BITS     = COORD_BITS + FRAC_BITS;
  localparam int STEP_BITS    = FRAC_BITS + 2;
  localparam int DIV_CNT_BITS = $clog2(ACC_BITS + 1);
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_ADVANCE = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic   is_start;
    coord_t sx;
    coord_t sy;
    coord_t adx;
    coord_t ady;
    coord_t steps;
    logic   x_neg;
    logic   y_neg;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/dlr_front.sv =====
// front end: takes input words and classifies them into line commands
`default_nettype none
module dlr_front (
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic            func,
  input  wire dlr_pkg::coord_t start_x,
  input  wire dlr_pkg::coord_t start_y,
  input  wire dlr_pkg::coord_t end_x,
  input  wire dlr_pkg::coord_t end_y,
  input  wire logic            queue_full,
  output logic                 push,
  output dlr_pkg::cmd_t        push_cmd
);

  dlr_pkg::coord_t adx;
  dlr_pkg::coord_t ady;
  logic            x_neg;
  logic            y_neg;

  always_comb begin
    x_neg = end_x < start_x;
    y_neg = end_y < start_y;
    adx   = x_neg ? (start_x - end_x) : (end_x - start_x);
    ady   = y_neg ? (start_y - end_y) : (end_y - start_y);
  end

  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  always_comb begin
    push_cmd.is_start = (func == dlr_pkg::FUNC_START);
    push_cmd.sx       = start_x;
    push_cmd.sy       = start_y;
    push_cmd.adx      = adx;
    push_cmd.ady      = ady;
    push_cmd.steps    = (adx > ady) ? adx : ady;
    push_cmd.x_neg    = x_neg;
    push_cmd.y_neg    = y_neg;
  end

endmodule
`default_nettype wire

// ===== rtl/dlr_queue.sv =====
// short command queue between front and back
`default_nettype none
module dlr_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire dlr_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output dlr_pkg::cmd_t      pop_cmd,
  output logic               full,
  output logic               not_empty
);

  dlr_pkg::cmd_t                 mem [dlr_pkg::QUEUE_DEPTH];
  logic [dlr_pkg::QPTR_BITS-1:0] wr_ptr;
  logic [dlr_pkg::QPTR_BITS-1:0] rd_ptr;
  logic [dlr_pkg::QCNT_BITS-1:0] count;
  logic                          do_push;
  logic                          do_pop;

  assign full      = (count == dlr_pkg::QCNT_BITS'(dlr_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == dlr_pkg::QPTR_BITS'(dlr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == dlr_pkg::QPTR_BITS'(dlr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dlr_back.sv =====
// back end: increment divider, accumulators and pixel output register
`default_nettype none
module dlr_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_avail,
  input  wire dlr_pkg::cmd_t cmd,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output dlr_pkg::coord_t    pixel_x,
  output dlr_pkg::coord_t    pixel_y,
  output logic               last_pixel
);

  localparam int CB = dlr_pkg::COORD_BITS;
  localparam int FB = dlr_pkg::FRAC_BITS;
  localparam int AB = dlr_pkg::ACC_BITS;
  localparam int SB = dlr_pkg::STEP_BITS;

  typedef enum logic {S_RUN, S_DIV} state_t;

  state_t                           state;
  logic                             drawing;
  logic [AB-1:0]                    x_accum;
  logic [AB-1:0]                    y_accum;
  logic [SB-1:0]                    x_step;
  logic [SB-1:0]                    y_step;
  dlr_pkg::coord_t                  steps_left;
  logic                             x_neg;
  logic                             y_neg;
  logic [AB-1:0]                    num_x;
  logic [AB-1:0]                    num_y;
  logic [CB:0]                      rem_x;
  logic [CB:0]                      rem_y;
  logic [dlr_pkg::DIV_CNT_BITS-1:0] div_cnt;

  logic [AB-1:0]   x_accum_next;
  logic [AB-1:0]   y_accum_next;
  dlr_pkg::coord_t steps_left_next;
  logic [CB:0]     rem_x_sh;
  logic [CB:0]     rem_y_sh;
  logic            qx;
  logic            qy;
  logic [SB-1:0]   mag_x;
  logic [SB-1:0]   mag_y;
  logic            pixel_load;

  assign pop = (state == S_RUN) && cmd_avail && (!out_valid || !out_stall);

  // a popped command gives a pixel unless it is an advance while idle
  assign pixel_load = pop && (cmd.is_start || drawing);

  always_comb begin
    x_accum_next    = x_accum + {{(AB-SB){x_step[SB-1]}}, x_step};
    y_accum_next    = y_accum + {{(AB-SB){y_step[SB-1]}}, y_step};
    steps_left_next = steps_left - 1'b1;
    rem_x_sh        = {rem_x[CB-1:0], num_x[AB-1]};
    rem_y_sh        = {rem_y[CB-1:0], num_y[AB-1]};
    qx              = rem_x_sh >= {1'b0, steps_left};
    qy              = rem_y_sh >= {1'b0, steps_left};
    mag_x           = {1'b0, num_x[FB:0]};
    mag_y           = {1'b0, num_y[FB:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_RUN;
      drawing    <= 1'b0;
      out_valid  <= 1'b0;
      x_accum    <= '0;
      y_accum    <= '0;
      x_step     <= '0;
      y_step     <= '0;
      steps_left <= '0;
      div_cnt    <= '0;
    end else begin
      if (pixel_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_RUN: begin
          if (pop) begin
            if (cmd.is_start) begin
              x_accum    <= {cmd.sx, {FB{1'b0}}};
              y_accum    <= {cmd.sy, {FB{1'b0}}};
              steps_left <= cmd.steps;
              pixel_x    <= cmd.sx;
              pixel_y    <= cmd.sy;
              x_neg      <= cmd.x_neg;
              y_neg      <= cmd.y_neg;
              num_x      <= {cmd.adx, {FB{1'b0}}};
              num_y      <= {cmd.ady, {FB{1'b0}}};
              rem_x      <= '0;
              rem_y      <= '0;
              div_cnt    <= dlr_pkg::DIV_CNT_BITS'(AB);
              if (cmd.steps == '0) begin
                x_step     <= '0;
                y_step     <= '0;
                drawing    <= 1'b0;
                last_pixel <= 1'b1;
              end else begin
                drawing    <= 1'b1;
                last_pixel <= 1'b0;
                state      <= S_DIV;
              end
            end else if (drawing) begin
              x_accum    <= x_accum_next;
              y_accum    <= y_accum_next;
              steps_left <= steps_left_next;
              pixel_x    <= x_accum_next[AB-1:FB];
              pixel_y    <= y_accum_next[AB-1:FB];
              last_pixel <= (steps_left_next == '0);
              if (steps_left_next == '0) begin
                drawing <= 1'b0;
              end
            end
          end
        end
        S_DIV: begin
          if (div_cnt != '0) begin
            rem_x   <= qx ? (rem_x_sh - {1'b0, steps_left}) : rem_x_sh;
            rem_y   <= qy ? (rem_y_sh - {1'b0, steps_left}) : rem_y_sh;
            num_x   <= {num_x[AB-2:0], qx};
            num_y   <= {num_y[AB-2:0], qy};
            div_cnt <= div_cnt - 1'b1;
          end else begin
            x_step <= x_neg ? (SB'(0) - mag_x) : mag_x;
            y_step <= y_neg ? (SB'(0) - mag_y) : mag_y;
            state  <= S_RUN;
          end
        end
        default: state <= S_RUN;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dda_line_rasterizer_unit.sv =====
// top level of the dda line rasterizer
//
// input channel: in_valid / in_stall carry one word with func and two
// endpoints. func start loads a segment and gives its first pixel; func
// advance gives the next pixel, and is dropped with no output while no
// segment is being drawn. a start with equal endpoints gives one pixel
// flagged last_pixel.
// output channel: out_valid / out_stall carry pixel_x, pixel_y, last_pixel.
// an accepted word passes the command queue and then the pixel output register.
// throughput: advance words run at one per cycle while the receiver does not
// stall. a start word holds the back end after its first pixel while the
// restoring divider forms both increments one quotient bit per cycle; a
// two-word command queue keeps taking input meanwhile.
// reset (rst, synchronous) empties the queue, drops any segment and clears
// out_valid.
// when the receiver stalls, the pixel word holds, the back end stops taking
// commands, and once the queue fills in_stall rises.
`default_nettype none
module dda_line_rasterizer_unit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic            func,
  input  wire dlr_pkg::coord_t start_x,
  input  wire dlr_pkg::coord_t start_y,
  input  wire dlr_pkg::coord_t end_x,
  input  wire dlr_pkg::coord_t end_y,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output dlr_pkg::coord_t      pixel_x,
  output dlr_pkg::coord_t      pixel_y,
  output logic                 last_pixel
);

  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_not_empty;
  dlr_pkg::cmd_t push_cmd;
  dlr_pkg::cmd_t pop_cmd;

  dlr_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .queue_full (q_full),
    .push       (q_push),
    .push_cmd   (push_cmd)
  );

  dlr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .pop       (q_pop),
    .pop_cmd   (pop_cmd),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  dlr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_avail  (q_not_empty),
    .cmd        (pop_cmd),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .last_pixel (last_pixel)
  );

endmodule
`default_nettype wire

// ===== rtl/dlr_checker.sv =====
// port-level checks of the dda line rasterizer and their binding
`default_nettype none
module dlr_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            in_valid,
  input wire logic            in_stall,
  input wire logic            out_valid,
  input wire logic            out_stall,
  input wire dlr_pkg::coord_t pixel_x,
  input wire dlr_pkg::coord_t pixel_y,
  input wire logic            last_pixel
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled output word dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(pixel_x) && $stable(pixel_y) && $stable(last_pixel))
    else $error("stalled output word changed");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("reset left output or queue busy");

  a_stall_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(in_valid) && !$past(in_stall))
    else $error("queue filled with no input word taken");

endmodule

bind dda_line_rasterizer_unit dlr_checker u_dlr_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .pixel_x    (pixel_x),
  .pixel_y    (pixel_y),
  .last_pixel (last_pixel)
);
`default_nettype wire
